// ===== hdl/mpe_channel_allocator_assert.svh =====
`ifndef MPE_CHANNEL_ALLOCATOR_ASSERT_SVH
`define MPE_CHANNEL_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define MPE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define MPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/mpe_pkg.sv =====
package mpe_pkg;

   typedef enum logic [1:0] {
      MODE_ON  = 2'd0,
      MODE_OFF = 2'd1,
      MODE_UPD = 2'd2,
      MODE_ALL = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      OP_ON,
      OP_OFF,
      OP_UPD,
      OP_ALL,
      OP_DROP
   } op_type;

   typedef enum logic [1:0] {
      KIND_NOTE_OFF = 2'd0,
      KIND_NOTE_ON  = 2'd1,
      KIND_WHEEL    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FREE_SCAN,
      ST_OLD_SCAN,
      ST_STEAL,
      ST_MUL,
      ST_DIV,
      ST_WHEEL,
      ST_NOTE_ON,
      ST_CHECK,
      ST_ALL_SCAN
   } state_type;

   localparam logic CSR_MEMBERS = 1'b0;
   localparam logic CSR_BEND    = 1'b1;

   localparam logic [6:0]  RANGE_MAX      = 7'd96;
   localparam logic [20:0] BEND_THRESHOLD = 21'd81;
   localparam logic [20:0] WHEEL_MAX      = 21'd16383;
   localparam logic [4:0]  DIV_STEPS      = 5'd21;

   typedef struct packed {
      logic [15:0]        note_tag;
      logic [3:0]         channel;
      logic [6:0]         pitch;
      logic [6:0]         velocity;
      logic [6:0]         release_velocity;
      logic signed [19:0] bend_offset;
   } item_type;

   typedef struct packed {
      op_type   op;
      item_type item;
   } entry_type;

endpackage

// ===== hdl/mpe_front.sv =====
module mpe_front #(
   parameter int CW          = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          mode,
   input  mpe_pkg::item_type   item,
   input  logic [CW-1:0]       zone_size,
   output logic                q_valid,
   output mpe_pkg::entry_type  q_entry,
   input  logic                q_pop
);

   mpe_pkg::entry_type fifo_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   mpe_pkg::entry_type new_entry;
   logic               push;
   logic               pop;

   always_comb begin
      new_entry.item = item;
      case (mpe_pkg::mode_type'(mode))
         mpe_pkg::MODE_ON:  new_entry.op = mpe_pkg::OP_ON;
         mpe_pkg::MODE_ALL: new_entry.op = mpe_pkg::OP_ALL;
         mpe_pkg::MODE_OFF, mpe_pkg::MODE_UPD: begin
            if (item.channel >= 4'd1 && item.channel <= 4'(zone_size)) begin
               new_entry.op = (mpe_pkg::mode_type'(mode) == mpe_pkg::MODE_OFF) ?
                              mpe_pkg::OP_OFF : mpe_pkg::OP_UPD;
            end else begin
               new_entry.op = mpe_pkg::OP_DROP;
            end
         end
         default: new_entry.op = mpe_pkg::OP_DROP;
      endcase
   end

   assign busy    = (count_ff == 2'd2);
   assign push    = start && !busy;
   assign q_valid = (count_ff != 2'd0);
   assign pop     = q_pop && q_valid;
   assign q_entry = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ===== hdl/mpe_back.sv =====
module mpe_back #(
   parameter int MAX_MEMBERS = 14,
   parameter int CW          = 4,
   parameter int IW          = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  mpe_pkg::entry_type q_entry,
   output logic               q_pop,
   input  logic [CW-1:0]      zone_size,
   input  logic [6:0]         bend_range,
   output logic               rsp_valid,
   output logic [1:0]         rsp_msg_kind,
   output logic [3:0]         rsp_out_channel,
   output logic [6:0]         rsp_note_number,
   output logic [6:0]         rsp_out_velocity,
   output logic [13:0]        rsp_wheel_value,
   output logic               rsp_last
);

   mpe_pkg::state_type state_ff, state_in;
   mpe_pkg::op_type    op_ff, op_in;
   mpe_pkg::item_type  cur_ff, cur_in;
   logic [CW-1:0]      s_ff, s_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [31:0]        best_ff, best_in;
   logic               found_ff, found_in;
   logic [31:0]        counter_ff, counter_in;
   logic [20:0]        num_ff, num_in;
   logic [6:0]         rem_ff, rem_in;
   logic [4:0]         div_cnt_ff, div_cnt_in;

   logic [MAX_MEMBERS-1:0] in_use_ff, in_use_in;
   logic [15:0]            tag_ff   [MAX_MEMBERS];
   logic [6:0]             pitch_ff [MAX_MEMBERS];
   logic [6:0]             rvel_ff  [MAX_MEMBERS];
   logic [31:0]            order_ff [MAX_MEMBERS];
   logic signed [19:0]     lbend_ff [MAX_MEMBERS];

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_kind_ff, rsp_kind_in;
   logic [3:0]             rsp_chan_ff, rsp_chan_in;
   logic [6:0]             rsp_note_ff, rsp_note_in;
   logic [6:0]             rsp_vel_ff, rsp_vel_in;
   logic [13:0]            rsp_wheel_ff, rsp_wheel_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   alloc_en;
   logic                   bend_we;
   logic [IW-1:0]          s_idx;
   logic [IW-1:0]          chan_idx;
   logic                   more_above;
   logic [18:0]            lim;
   logic signed [20:0]     bend_c;
   logic signed [20:0]     bend_sum;
   logic [33:0]            wnum;
   logic signed [20:0]     bend_diff;
   logic [20:0]            bend_abs;
   logic [7:0]             rem_sh;

   assign s_idx    = s_ff[IW-1:0];
   assign chan_idx = IW'(cur_ff.channel - 4'd1);

   always_comb begin
      more_above = 1'b0;
      for (int i = 0; i < MAX_MEMBERS; i++) begin
         if (in_use_ff[i] && (CW'(i) > s_ff) && (CW'(i) < zone_size)) begin
            more_above = 1'b1;
         end
      end
   end

   always_comb begin
      lim = {bend_range, 12'd0};
      if (cur_ff.bend_offset > $signed({2'b00, lim})) begin
         bend_c = $signed({2'b00, lim});
      end else if (21'(cur_ff.bend_offset) < -$signed({2'b00, lim})) begin
         bend_c = -$signed({2'b00, lim});
      end else begin
         bend_c = 21'(cur_ff.bend_offset);
      end
      bend_sum  = bend_c + $signed({2'b00, lim});
      wnum      = ({14'd0, bend_sum[19:0]} << 14) - ({14'd0, bend_sum[19:0]} << 1)
                + ({27'd0, bend_range} << 13) + ({27'd0, bend_range} << 12);
      bend_diff = 21'(cur_ff.bend_offset) - 21'(lbend_ff[chan_idx]);
      bend_abs  = bend_diff[20] ? 21'(-bend_diff) : 21'(bend_diff);
      rem_sh    = {rem_ff, num_ff[20]};
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cur_in       = cur_ff;
      s_in         = s_ff;
      slot_in      = slot_ff;
      best_in      = best_ff;
      found_in     = found_ff;
      counter_in   = counter_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      in_use_in    = in_use_ff;
      q_pop        = 1'b0;
      alloc_en     = 1'b0;
      bend_we      = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = mpe_pkg::KIND_NOTE_OFF;
      rsp_chan_in  = 4'(slot_ff) + 4'd1;
      rsp_note_in  = 7'd0;
      rsp_vel_in   = 7'd0;
      rsp_wheel_in = 14'd0;
      rsp_last_in  = 1'b0;

      case (state_ff)
         mpe_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               op_in    = q_entry.op;
               cur_in   = q_entry.item;
               s_in     = '0;
               best_in  = 32'hFFFF_FFFF;
               found_in = 1'b0;
               case (q_entry.op)
                  mpe_pkg::OP_ON:  state_in = mpe_pkg::ST_FREE_SCAN;
                  mpe_pkg::OP_OFF,
                  mpe_pkg::OP_UPD: state_in = mpe_pkg::ST_CHECK;
                  mpe_pkg::OP_ALL: state_in = mpe_pkg::ST_ALL_SCAN;
                  default:         state_in = mpe_pkg::ST_IDLE;
               endcase
            end
         end
         mpe_pkg::ST_FREE_SCAN: begin
            if (s_ff == zone_size) begin
               s_in     = '0;
               state_in = mpe_pkg::ST_OLD_SCAN;
            end else if (!in_use_ff[s_idx]) begin
               slot_in  = s_idx;
               state_in = mpe_pkg::ST_MUL;
            end else begin
               s_in = s_ff + CW'(1);
            end
         end
         mpe_pkg::ST_OLD_SCAN: begin
            if (s_ff == zone_size) begin
               state_in = found_ff ? mpe_pkg::ST_STEAL : mpe_pkg::ST_IDLE;
            end else begin
               if (order_ff[s_idx] < best_ff) begin
                  best_in  = order_ff[s_idx];
                  slot_in  = s_idx;
                  found_in = 1'b1;
               end
               s_in = s_ff + CW'(1);
            end
         end
         mpe_pkg::ST_STEAL: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mpe_pkg::KIND_NOTE_OFF;
            rsp_note_in  = pitch_ff[slot_ff];
            rsp_vel_in   = rvel_ff[slot_ff];
            state_in     = mpe_pkg::ST_MUL;
         end
         mpe_pkg::ST_MUL: begin
            if (op_ff == mpe_pkg::OP_ON) begin
               alloc_en            = 1'b1;
               in_use_in[slot_ff]  = 1'b1;
               counter_in          = counter_ff + 32'd1;
            end
            num_in     = wnum[33:13];
            rem_in     = 7'd0;
            div_cnt_in = 5'd0;
            state_in   = mpe_pkg::ST_DIV;
         end
         mpe_pkg::ST_DIV: begin
            if (rem_sh >= {1'b0, bend_range}) begin
               rem_in = 7'(rem_sh - {1'b0, bend_range});
               num_in = {num_ff[19:0], 1'b1};
            end else begin
               rem_in = rem_sh[6:0];
               num_in = {num_ff[19:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == mpe_pkg::DIV_STEPS - 5'd1) begin
               state_in = mpe_pkg::ST_WHEEL;
            end
         end
         mpe_pkg::ST_WHEEL: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mpe_pkg::KIND_WHEEL;
            rsp_wheel_in = (num_ff > mpe_pkg::WHEEL_MAX) ? 14'h3FFF : num_ff[13:0];
            rsp_last_in  = (op_ff != mpe_pkg::OP_ON);
            state_in     = (op_ff == mpe_pkg::OP_ON) ? mpe_pkg::ST_NOTE_ON : mpe_pkg::ST_IDLE;
         end
         mpe_pkg::ST_NOTE_ON: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mpe_pkg::KIND_NOTE_ON;
            rsp_note_in  = cur_ff.pitch;
            rsp_vel_in   = cur_ff.velocity;
            rsp_last_in  = 1'b1;
            state_in     = mpe_pkg::ST_IDLE;
         end
         mpe_pkg::ST_CHECK: begin
            slot_in  = chan_idx;
            state_in = mpe_pkg::ST_IDLE;
            if (in_use_ff[chan_idx] && tag_ff[chan_idx] == cur_ff.note_tag) begin
               if (op_ff == mpe_pkg::OP_OFF) begin
                  rsp_valid_in        = 1'b1;
                  rsp_kind_in         = mpe_pkg::KIND_NOTE_OFF;
                  rsp_chan_in         = cur_ff.channel;
                  rsp_note_in         = pitch_ff[chan_idx];
                  rsp_vel_in          = rvel_ff[chan_idx];
                  rsp_last_in         = 1'b1;
                  in_use_in[chan_idx] = 1'b0;
               end else if (bend_abs > mpe_pkg::BEND_THRESHOLD) begin
                  bend_we  = 1'b1;
                  state_in = mpe_pkg::ST_MUL;
               end
            end
         end
         mpe_pkg::ST_ALL_SCAN: begin
            if (s_ff == zone_size) begin
               state_in = mpe_pkg::ST_IDLE;
            end else begin
               if (in_use_ff[s_idx]) begin
                  rsp_valid_in     = 1'b1;
                  rsp_kind_in      = mpe_pkg::KIND_NOTE_OFF;
                  rsp_chan_in      = 4'(s_idx) + 4'd1;
                  rsp_note_in      = pitch_ff[s_idx];
                  rsp_last_in      = !more_above;
                  in_use_in[s_idx] = 1'b0;
               end
               s_in = s_ff + CW'(1);
            end
         end
         default: state_in = mpe_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpe_pkg::ST_IDLE;
         in_use_ff    <= '0;
         counter_ff   <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_use_ff    <= in_use_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cur_ff       <= cur_in;
      s_ff         <= s_in;
      slot_ff      <= slot_in;
      best_ff      <= best_in;
      found_ff     <= found_in;
      num_ff       <= num_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_note_ff  <= rsp_note_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_wheel_ff <= rsp_wheel_in;
      rsp_last_ff  <= rsp_last_in;
      if (alloc_en) begin
         tag_ff[slot_ff]   <= cur_ff.note_tag;
         pitch_ff[slot_ff] <= cur_ff.pitch;
         rvel_ff[slot_ff]  <= cur_ff.release_velocity;
         order_ff[slot_ff] <= counter_ff + 32'd1;
         lbend_ff[slot_ff] <= cur_ff.bend_offset;
      end
      if (bend_we) begin
         lbend_ff[chan_idx] <= cur_ff.bend_offset;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_msg_kind     = rsp_kind_ff;
   assign rsp_out_channel  = rsp_chan_ff;
   assign rsp_note_number  = rsp_note_ff;
   assign rsp_out_velocity = rsp_vel_ff;
   assign rsp_wheel_value  = rsp_wheel_ff;
   assign rsp_last         = rsp_last_ff;

`include "mpe_channel_allocator_assert.svh"

   `MPE_ASSERT_IMP(a_on_after_wheel, clock, reset,
      rsp_valid_ff && rsp_kind_ff == mpe_pkg::KIND_NOTE_ON,
      $past(rsp_valid_ff) && $past(rsp_kind_ff) == mpe_pkg::KIND_WHEEL)
   `MPE_ASSERT_IMP(a_on_slot_busy, clock, reset,
      rsp_valid_ff && rsp_kind_ff == mpe_pkg::KIND_NOTE_ON, in_use_ff[slot_ff])
   `MPE_ASSERT_IMP(a_more_follow, clock, reset,
      rsp_valid_ff && !rsp_last_ff, state_ff != mpe_pkg::ST_IDLE)
   `MPE_ASSERT_NEXT(a_wheel_then_on, clock, reset,
      rsp_valid_ff && rsp_kind_ff == mpe_pkg::KIND_WHEEL && !rsp_last_ff,
      rsp_valid_ff && rsp_kind_ff == mpe_pkg::KIND_NOTE_ON)

endmodule

// ===== hdl/mpe_channel_allocator.sv =====
// Each request is handled to completion before the next is taken from the queue:
// note-on scans for a free slot (else steals the oldest, with a note-off), then emits
// a wheel value from the serial divider and the note-on; note-off checks the slot;
// update emits a wheel value if the bend moved; all-notes-off scans the zone. A 2-entry queue absorbs bursts.
// Synchronous active-high reset frees every channel and restores 14 members,
// bend range 48. Results are strobed for one cycle; the receiver cannot stall.
module mpe_channel_allocator #(
   parameter int MAX_MEMBERS = 14
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_note_tag,
   input  logic [3:0]  req_channel,
   input  logic [6:0]  req_pitch,
   input  logic [6:0]  req_velocity,
   input  logic [6:0]  req_release_velocity,
   input  logic signed [19:0] req_bend_offset,
   output logic        rsp_valid,
   output logic [1:0]  rsp_msg_kind,
   output logic [3:0]  rsp_out_channel,
   output logic [6:0]  rsp_note_number,
   output logic [6:0]  rsp_out_velocity,
   output logic [13:0] rsp_wheel_value,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [6:0]  csr_data
);

   localparam int CW = $clog2(MAX_MEMBERS + 1);
   localparam int IW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

   logic [3:0]         members_ff;
   logic [6:0]         range_ff;
   logic [CW-1:0]      zone_size;
   logic [6:0]         bend_range;
   mpe_pkg::item_type  item;
   mpe_pkg::entry_type q_entry;
   logic               q_valid;
   logic               q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         members_ff <= 4'd14;
         range_ff   <= 7'd48;
      end else if (csr_valid) begin
         case (csr_index)
            mpe_pkg::CSR_MEMBERS: members_ff <= csr_data[3:0];
            mpe_pkg::CSR_BEND:    range_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (members_ff == 4'd0) begin
         zone_size = CW'(1);
      end else if (5'(members_ff) > 5'(MAX_MEMBERS)) begin
         zone_size = CW'(MAX_MEMBERS);
      end else begin
         zone_size = CW'(members_ff);
      end
      if (range_ff == 7'd0) begin
         bend_range = 7'd1;
      end else if (range_ff > mpe_pkg::RANGE_MAX) begin
         bend_range = mpe_pkg::RANGE_MAX;
      end else begin
         bend_range = range_ff;
      end
   end

   assign item.note_tag         = req_note_tag;
   assign item.channel          = req_channel;
   assign item.pitch            = req_pitch;
   assign item.velocity         = req_velocity;
   assign item.release_velocity = req_release_velocity;
   assign item.bend_offset      = req_bend_offset;

   mpe_front #(
      .CW          (CW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .mode      (req_mode),
      .item      (item),
      .zone_size (zone_size),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop)
   );

   mpe_back #(
      .MAX_MEMBERS (MAX_MEMBERS),
      .CW          (CW),
      .IW          (IW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (q_entry),
      .q_pop            (q_pop),
      .zone_size        (zone_size),
      .bend_range       (bend_range),
      .rsp_valid        (rsp_valid),
      .rsp_msg_kind     (rsp_msg_kind),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_note_number  (rsp_note_number),
      .rsp_out_velocity (rsp_out_velocity),
      .rsp_wheel_value  (rsp_wheel_value),
      .rsp_last         (rsp_last)
   );

endmodule
